// File: rtl/ray_triangle_intersect_core_defines.svh
// Assertion macros used by the checker file.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH

// same-cycle implication
`define RTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// checked during reset as well
`define RTI_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/rti_pkg.sv
// Shared widths, register codes and constants of the ray/triangle core.
`default_nettype none
package rti_pkg;
  localparam int COORD_W   = 32;
  localparam int VTX_NUM   = 9;
  localparam int DIFF_W    = COORD_W + 1;        // vertex differences
  localparam int PROD_W    = 2 * DIFF_W;         // cross partial products
  localparam int CROSS_W   = PROD_W + 1;         // cross product components
  localparam int LO_W      = 34;                 // low split of a cross component
  localparam int MH_W      = (CROSS_W - LO_W) + DIFF_W;
  localparam int ML_W      = (LO_W + 1) + DIFF_W;
  localparam int DOT_W     = 101;                // dot products, exact
  localparam int Q_W       = 31;                 // quotient bits before saturation
  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W    = 5;
  localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;
endpackage
`default_nettype wire

// File: rtl/rti_cross.sv
// Edge vectors and the two cross products, three register stages.
`default_nettype none
module rti_cross (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire rti_pkg::stage_ctl_t              ctl,
  input  wire [rti_pkg::VTX_NUM*rti_pkg::COORD_W-1:0] vtx,
  input  wire logic signed [rti_pkg::COORD_W-1:0] org [3],
  input  wire logic signed [rti_pkg::COORD_W-1:0] dir [3],
  output logic                                  valid,
  output logic signed [rti_pkg::CROSS_W-1:0]    p [3],
  output logic signed [rti_pkg::CROSS_W-1:0]    q [3],
  output logic signed [rti_pkg::DIFF_W-1:0]     e1 [3],
  output logic signed [rti_pkg::DIFF_W-1:0]     e2 [3],
  output logic signed [rti_pkg::DIFF_W-1:0]     sv [3]
);
  logic signed [rti_pkg::COORD_W-1:0] v0 [3];
  logic signed [rti_pkg::COORD_W-1:0] v1 [3];
  logic signed [rti_pkg::COORD_W-1:0] v2 [3];
  logic signed [rti_pkg::DIFF_W-1:0]  e1_a [3], e2_a [3], s_a [3];
  logic signed [rti_pkg::DIFF_W-1:0]  e1_b [3], e2_b [3], s_b [3];
  logic signed [rti_pkg::DIFF_W-1:0]  d [3];
  logic signed [rti_pkg::PROD_W-1:0]  pm [6], qm [6];
  logic [1:0]                         vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0[i] = $signed(vtx[i*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
      v1[i] = $signed(vtx[(i+3)*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
      v2[i] = $signed(vtx[(i+6)*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
      d[i]  = rti_pkg::DIFF_W'(dir[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      vld   <= {vld[0], ctl.valid};
      valid <= vld[1];
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        e1_a[i] <= rti_pkg::DIFF_W'(v1[i]) - rti_pkg::DIFF_W'(v0[i]);
        e2_a[i] <= rti_pkg::DIFF_W'(v2[i]) - rti_pkg::DIFF_W'(v0[i]);
        s_a[i]  <= rti_pkg::DIFF_W'(org[i]) - rti_pkg::DIFF_W'(v0[i]);
      end
    end
  end

  // stage 2: partial products, p = dir x e2, q = s x e1
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pm[0] <= rti_pkg::PROD_W'(d[1]) * rti_pkg::PROD_W'(e2_a[2]);
      pm[1] <= rti_pkg::PROD_W'(d[2]) * rti_pkg::PROD_W'(e2_a[1]);
      pm[2] <= rti_pkg::PROD_W'(d[2]) * rti_pkg::PROD_W'(e2_a[0]);
      pm[3] <= rti_pkg::PROD_W'(d[0]) * rti_pkg::PROD_W'(e2_a[2]);
      pm[4] <= rti_pkg::PROD_W'(d[0]) * rti_pkg::PROD_W'(e2_a[1]);
      pm[5] <= rti_pkg::PROD_W'(d[1]) * rti_pkg::PROD_W'(e2_a[0]);
      qm[0] <= rti_pkg::PROD_W'(s_a[1]) * rti_pkg::PROD_W'(e1_a[2]);
      qm[1] <= rti_pkg::PROD_W'(s_a[2]) * rti_pkg::PROD_W'(e1_a[1]);
      qm[2] <= rti_pkg::PROD_W'(s_a[2]) * rti_pkg::PROD_W'(e1_a[0]);
      qm[3] <= rti_pkg::PROD_W'(s_a[0]) * rti_pkg::PROD_W'(e1_a[2]);
      qm[4] <= rti_pkg::PROD_W'(s_a[0]) * rti_pkg::PROD_W'(e1_a[1]);
      qm[5] <= rti_pkg::PROD_W'(s_a[1]) * rti_pkg::PROD_W'(e1_a[0]);
      e1_b <= e1_a;
      e2_b <= e2_a;
      s_b  <= s_a;
    end
  end

  // stage 3: cross components
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        p[i] <= rti_pkg::CROSS_W'(pm[2*i]) - rti_pkg::CROSS_W'(pm[2*i+1]);
        q[i] <= rti_pkg::CROSS_W'(qm[2*i]) - rti_pkg::CROSS_W'(qm[2*i+1]);
      end
      e1 <= e1_b;
      e2 <= e2_b;
      sv <= s_b;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rti_dot.sv
// The four dot products det, T, U, V, split multiplies, three stages.
`default_nettype none
module rti_dot (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire rti_pkg::stage_ctl_t             ctl,
  input  wire logic signed [rti_pkg::CROSS_W-1:0] p [3],
  input  wire logic signed [rti_pkg::CROSS_W-1:0] q [3],
  input  wire logic signed [rti_pkg::DIFF_W-1:0]  e1 [3],
  input  wire logic signed [rti_pkg::DIFF_W-1:0]  e2 [3],
  input  wire logic signed [rti_pkg::DIFF_W-1:0]  sv [3],
  input  wire logic signed [rti_pkg::COORD_W-1:0] dir [3],
  output logic                                 valid,
  output logic signed [rti_pkg::DOT_W-1:0]     dot [4]
);
  logic signed [rti_pkg::CROSS_W-1:0] a [12];
  logic signed [rti_pkg::DIFF_W-1:0]  b [12];
  logic signed [rti_pkg::MH_W-1:0]    mh [12];
  logic signed [rti_pkg::ML_W-1:0]    ml [12];
  logic signed [rti_pkg::DOT_W-1:0]   term [12];
  logic [1:0]                         vld;

  // dot 0: p.e1, 1: q.e2, 2: p.s, 3: q.dir
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a[c]   = p[c];  b[c]   = e1[c];
      a[3+c] = q[c];  b[3+c] = e2[c];
      a[6+c] = p[c];  b[6+c] = sv[c];
      a[9+c] = q[c];  b[9+c] = rti_pkg::DIFF_W'(dir[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      vld   <= {vld[0], ctl.valid};
      valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < 12; k++) begin
        mh[k] <= rti_pkg::MH_W'($signed(a[k][rti_pkg::CROSS_W-1:rti_pkg::LO_W]))
                 * rti_pkg::MH_W'(b[k]);
        ml[k] <= rti_pkg::ML_W'($signed({1'b0, a[k][rti_pkg::LO_W-1:0]}))
                 * rti_pkg::ML_W'(b[k]);
      end
      for (int k = 0; k < 12; k++) begin
        term[k] <= (rti_pkg::DOT_W'(mh[k]) <<< rti_pkg::LO_W) + rti_pkg::DOT_W'(ml[k]);
      end
      for (int j = 0; j < 4; j++) begin
        dot[j] <= term[3*j] + term[3*j+1] + term[3*j+2];
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/rti_div.sv
// Sign fold, hit tests and a pipelined restoring divide for t.
`default_nettype none
module rti_div #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire rti_pkg::stage_ctl_t          ctl,
  input  wire logic signed [rti_pkg::DOT_W-1:0] dot [4],
  output logic                              valid,
  output logic                              hit,
  output logic [rti_pkg::COORD_W-1:0]       distance
);
  localparam int R_W = rti_pkg::DOT_W + rti_pkg::Q_W + FRAC_BITS;
  localparam int NST = rti_pkg::Q_W + 1;

  logic signed [rti_pkg::DOT_W-1:0] det_m, tn_m, un_m, vn_m;
  logic                             nz;
  logic signed [rti_pkg::DOT_W:0]   uv;
  logic [rti_pkg::DOT_W-1:0]        den_c;
  logic [R_W-1:0]                   rem_c;
  logic                             pre_c;
  logic [R_W-1:0]                   rem_r [NST];
  logic [rti_pkg::Q_W-1:0]          q_r   [NST];
  logic [rti_pkg::DOT_W-1:0]        den_r [NST];
  logic                             pre_r [NST];
  logic                             sat_r [NST];
  logic [NST:0]                     vld;
  logic                             ok_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      vld   <= {vld[NST-1:0], ctl.valid};
      valid <= vld[NST];
    end
  end

  // fold the sign of det into all four
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      nz    <= dot[0] != '0;
      det_m <= dot[0][rti_pkg::DOT_W-1] ? -dot[0] : dot[0];
      tn_m  <= dot[0][rti_pkg::DOT_W-1] ? -dot[1] : dot[1];
      un_m  <= dot[0][rti_pkg::DOT_W-1] ? -dot[2] : dot[2];
      vn_m  <= dot[0][rti_pkg::DOT_W-1] ? -dot[3] : dot[3];
    end
  end

  always_comb begin
    uv    = (rti_pkg::DOT_W+1)'(un_m) + (rti_pkg::DOT_W+1)'(vn_m);
    ok_c  = uv <= (rti_pkg::DOT_W+1)'(det_m);
    pre_c = nz && !tn_m[rti_pkg::DOT_W-1] && !un_m[rti_pkg::DOT_W-1]
            && !vn_m[rti_pkg::DOT_W-1] && ok_c;
    den_c = det_m;
    rem_c = {{(R_W-rti_pkg::DOT_W){1'b0}}, tn_m} << FRAC_BITS;
  end

  // range tests and saturation check: quotient would need more than Q_W bits
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= rem_c;
      den_r[0] <= den_c;
      pre_r[0] <= pre_c;
      q_r[0]   <= '0;
      sat_r[0] <= rem_c >= ({{(R_W-rti_pkg::DOT_W){1'b0}}, den_c} << rti_pkg::Q_W);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < rti_pkg::Q_W; j++) begin : g_step
    localparam int K = rti_pkg::Q_W - 1 - j;
    logic [R_W:0] trial;
    always_comb begin
      trial = {1'b0, rem_r[j]}
              - ({{(R_W+1-rti_pkg::DOT_W){1'b0}}, den_r[j]} << K);
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[j+1] <= trial[R_W] ? rem_r[j] : trial[R_W-1:0];
        q_r[j+1]   <= q_r[j] | (rti_pkg::Q_W'(!trial[R_W]) << K);
        den_r[j+1] <= den_r[j];
        pre_r[j+1] <= pre_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  // result register; t below one lsb counts as a miss
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      hit <= pre_r[NST-1] && (sat_r[NST-1] || q_r[NST-1] != '0);
      if (!(pre_r[NST-1] && (sat_r[NST-1] || q_r[NST-1] != '0))) begin
        distance <= '0;
      end else if (sat_r[NST-1]) begin
        distance <= rti_pkg::DIST_MAX;
      end else begin
        distance <= {1'b0, q_r[NST-1]};
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/ray_triangle_intersect_core.sv
// Top level of the pipelined ray/triangle intersection core.
//
// Usage: write the ray (origin_x..z, direction_x..z, signed Q16.16) over
// the APB port at byte addresses 0x00..0x14 while the core is idle, then
// stream triangles on s_axis: one word per triangle, nine 32-bit signed
// coordinates. Each word gives one result word on m_axis: tuser is hit,
// tdata is the distance t (Q16.16, saturated to 0x7FFFFFFF, zero on miss).
// The pipe has 40 register stages: 3 stages of edges and cross products,
// 3 of dot products, 1 sign fold, 1 of range tests and saturation check,
// 31 divider stages (one quotient bit each) and the output register.
// Throughput is one triangle per cycle while m_axis is not stalled.
// Reset clears the ray registers to zero and drops every word in flight.
// When the receiver holds m_axis_tready low with a result pending, the
// whole pipe freezes and s_axis_tready falls, even when the pipe holds
// bubbles. Nothing is lost or repeated.
`default_nettype none
module ray_triangle_intersect_core #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst,
  // APB configuration
  input  wire                                       psel,
  input  wire                                       penable,
  input  wire                                       pwrite,
  input  wire  [rti_pkg::ADDR_W-1:0]                paddr,
  input  wire  [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready,
  // triangle stream
  input  wire                                       s_axis_tvalid,
  output logic                                      s_axis_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x..z, vert2_x..z (32 bits each)
  input  wire  [rti_pkg::VTX_NUM*rti_pkg::COORD_W-1:0] s_axis_tdata,
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire                                       m_axis_tready,
  // distance (32 bits)
  output logic [rti_pkg::COORD_W-1:0]               m_axis_tdata,
  // hit
  output logic                                      m_axis_tuser
);
  logic signed [rti_pkg::COORD_W-1:0] org [3];
  logic signed [rti_pkg::COORD_W-1:0] dir [3];
  rti_pkg::stage_ctl_t                ctl0, ctl1, ctl2;
  logic                               en;
  logic                               v_cross, v_dot;
  logic signed [rti_pkg::CROSS_W-1:0] p [3], q [3];
  logic signed [rti_pkg::DIFF_W-1:0]  e1 [3], e2 [3], sv [3];
  logic signed [rti_pkg::DOT_W-1:0]   dot [4];
  logic                               wr;

  // global advance: the output register is free or being drained
  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign pready        = 1'b1;
  assign wr            = psel && penable && pwrite;

  // ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else if (wr) begin
      case (rti_pkg::reg_idx_t'(paddr[4:2]))
        rti_pkg::REG_ORIGIN_X:    org[0] <= pwdata;
        rti_pkg::REG_ORIGIN_Y:    org[1] <= pwdata;
        rti_pkg::REG_ORIGIN_Z:    org[2] <= pwdata;
        rti_pkg::REG_DIRECTION_X: dir[0] <= pwdata;
        rti_pkg::REG_DIRECTION_Y: dir[1] <= pwdata;
        rti_pkg::REG_DIRECTION_Z: dir[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rti_pkg::reg_idx_t'(paddr[4:2]))
      rti_pkg::REG_ORIGIN_X:    prdata = org[0];
      rti_pkg::REG_ORIGIN_Y:    prdata = org[1];
      rti_pkg::REG_ORIGIN_Z:    prdata = org[2];
      rti_pkg::REG_DIRECTION_X: prdata = dir[0];
      rti_pkg::REG_DIRECTION_Y: prdata = dir[1];
      rti_pkg::REG_DIRECTION_Z: prdata = dir[2];
      default:                  prdata = '0;
    endcase
  end

  assign ctl0 = '{en: en, valid: s_axis_tvalid};
  assign ctl1 = '{en: en, valid: v_cross};
  assign ctl2 = '{en: en, valid: v_dot};

  rti_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl0),
    .vtx   (s_axis_tdata),
    .org   (org),
    .dir   (dir),
    .valid (v_cross),
    .p     (p),
    .q     (q),
    .e1    (e1),
    .e2    (e2),
    .sv    (sv)
  );

  rti_dot u_dot (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl1),
    .p     (p),
    .q     (q),
    .e1    (e1),
    .e2    (e2),
    .sv    (sv),
    .dir   (dir),
    .valid (v_dot),
    .dot   (dot)
  );

  rti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl2),
    .dot      (dot),
    .valid    (m_axis_tvalid),
    .hit      (m_axis_tuser),
    .distance (m_axis_tdata)
  );
endmodule
`default_nettype wire

// File: rtl/rti_checker.sv
// Port-level checks of the ray/triangle core, bound to the top level.
`default_nettype none
`include "ray_triangle_intersect_core_defines.svh"
module rti_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        m_axis_tuser
);
  `RTI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
  `RTI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0, "miss with nonzero distance")
  `RTI_ASSERT_NOW(a_hit_pos, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 32'd0 && !m_axis_tdata[31], "hit without positive distance")
  `RTI_ASSERT_ALWAYS(a_backpressure, m_axis_tvalid && !m_axis_tready && !rst, !s_axis_tready, "input taken while output stalled")
  `RTI_ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst, !m_axis_tvalid, "output valid right after reset")
endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (.*);
`default_nettype wire

// File: tb/tb_ray_triangle_intersect_core.sv
// Self-checking testbench of the ray/triangle intersection core.
`default_nettype none
module tb_ray_triangle_intersect_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = rti_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 40;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1290;
  localparam int LONG_HOLD = 400;

  typedef logic signed [31:0] coord_t;
  typedef struct {
    coord_t v [9];
  } tri_t;
  typedef struct {
    logic hit;
    logic [31:0] distance;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rti_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic s_axis_tvalid = 1'b0;
  wire s_axis_tready;
  // vert0_x, vert0_y, vert0_z, vert1_x..z, vert2_x..z
  logic [rti_pkg::VTX_NUM*rti_pkg::COORD_W-1:0] s_axis_tdata = '0;
  wire m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // distance
  wire [rti_pkg::COORD_W-1:0] m_axis_tdata;
  // hit
  wire m_axis_tuser;

  ray_triangle_intersect_core dut (.*);

  always #6 clk = ~clk;

  // testbench copy of the ray registers
  coord_t ray_reg [6];
  tri_t pending_tris [$];
  outcome_t expected_outcomes [$];
  bit failed = 0;
  bit hold_send = 0;
  int idle_cycles = 0;

  // exact Moller-Trumbore test in wide signed arithmetic
  function automatic outcome_t predict(tri_t t);
    logic signed [127:0] o [3], d [3], a [3], e1 [3], e2 [3], s [3], p [3], q [3];
    logic signed [127:0] det, tn, un, vn;
    logic [127:0] quo;
    outcome_t r;
    for (int k = 0; k < 3; k++) begin
      o[k] = ray_reg[k];
      d[k] = ray_reg[k+3];
      a[k] = t.v[k];
      e1[k] = 128'(signed'(t.v[k+3])) - a[k];
      e2[k] = 128'(signed'(t.v[k+6])) - a[k];
      s[k] = o[k] - a[k];
    end
    for (int k = 0; k < 3; k++) begin
      p[k] = d[(k+1)%3] * e2[(k+2)%3] - d[(k+2)%3] * e2[(k+1)%3];
      q[k] = s[(k+1)%3] * e1[(k+2)%3] - s[(k+2)%3] * e1[(k+1)%3];
    end
    det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
    tn  = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
    un  = p[0]*s[0]  + p[1]*s[1]  + p[2]*s[2];
    vn  = q[0]*d[0]  + q[1]*d[1]  + q[2]*d[2];
    r.hit = (det != 0);
    r.distance = '0;
    if (det < 0) begin
      det = -det; tn = -tn; un = -un; vn = -vn;
    end
    if (r.hit && (un < 0 || vn < 0 || tn < 0 || un + vn > det)) r.hit = 0;
    if (r.hit) begin
      quo = (tn <<< FB) / det;
      if (quo == 0) r.hit = 0;
      else r.distance = (quo > 128'h7FFFFFFF) ? rti_pkg::DIST_MAX : quo[31:0];
    end
    return r;
  endfunction

  task automatic apb_write(rti_pkg::reg_idx_t idx, coord_t val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= rti_pkg::ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ray_reg[idx] = val;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait for every result, then the pipe depth
  task automatic drain();
    wait (pending_tris.size() == 0 && expected_outcomes.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
    endcase
  endfunction

  // triangle around the z axis, 1 to 30 units beyond the origin z, with random jitter
  function automatic tri_t aimed_tri();
    tri_t t;
    int sz;
    sz = $urandom_range(1, 8) << FB;
    for (int k = 0; k < 9; k++) t.v[k] = $signed($urandom_range(0, 2*sz)) - sz;
    t.v[2] = ray_reg[2] + ($urandom_range(1, 30) << FB);
    t.v[5] = t.v[2] + $signed($urandom_range(0, 2 << FB)) - (1 << FB);
    t.v[8] = t.v[2] + $signed($urandom_range(0, 2 << FB)) - (1 << FB);
    return t;
  endfunction

  task automatic push_tri(tri_t t);
    pending_tris.push_back(t);
  endtask

  // ready as seen at the last rising edge
  logic s_axis_tready_q = 0;

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        // word taken at the last rising edge
      end
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (gap_left > 0 || hold_send || pending_tris.size() == 0) begin
          s_axis_tvalid <= 0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          for (int k = 0; k < 9; k++) s_axis_tdata[32*k +: 32] <= pending_tris[0].v[k];
          s_axis_tvalid <= 1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // accept side of the driver: predict at the accepting edge
  always @(posedge clk) begin
    s_axis_tready_q <= s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_outcomes.push_back(predict(pending_tris.pop_front()));
    end
  end

  // receiver stall pattern; a requested long hold is timed here
  int stall_phase = 0;
  int long_left = 0;
  bit long_req = 0;
  bit long_taken = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (long_left > 0) begin
      long_left <= long_left - 1;
      m_axis_tready <= 0;
    end else if (long_req && !long_taken) begin
      long_left <= LONG_HOLD;
      long_taken <= 1;
      m_axis_tready <= 0;
    end else if (stall_phase % 200 < 60) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result word with no expectation");
          failed = 1;
        end else begin
          e = expected_outcomes.pop_front();
          if (m_axis_tuser !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, m_axis_tuser);
            failed = 1;
          end
          if (m_axis_tdata !== e.distance) begin
            $error("distance: expected %h actual %h", e.distance, m_axis_tdata);
            failed = 1;
          end
        end
      end
    end
  end

  initial begin
    tri_t t;
    coord_t ray_sets [5][6];
    for (int k = 0; k < 6; k++) ray_reg[k] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
    // reset ray: zero direction, every triangle misses
    for (int k = 0; k < 9; k++) t.v[k] = k << FB;
    push_tri(t);
    drain();

    // ray settings: down +z, extremes, offset origin with tiny +z step, huge +z, random
    ray_sets[0] = '{0, 0, 0, 0, 0, 1 << FB};
    ray_sets[1] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                    32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    ray_sets[2] = '{1 << FB, -(2 << FB), -(40 << FB), 0, 0, 1};
    ray_sets[3] = '{0, 0, 0, 0, 0, 32'sh7FFFFFFF};
    ray_sets[4] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    for (int r = 0; r < 5; r++) begin
      for (int k = 0; k < 6; k++) apb_write(rti_pkg::reg_idx_t'(k), ray_sets[r][k]);
      if (r == 0) begin
        // directed: clean hit, edge on u=0, vertex hit, behind, degenerate,
        // parallel, extremes
        t.v = '{-(1<<FB), -(1<<FB), 5<<FB, 3<<FB, -(1<<FB), 5<<FB, -(1<<FB), 3<<FB, 5<<FB};
        push_tri(t);
        t.v = '{0, -(1<<FB), 5<<FB, 2<<FB, -(1<<FB), 5<<FB, 0, 2<<FB, 5<<FB};
        push_tri(t);
        t.v = '{0, 0, 5<<FB, 1<<FB, 0, 5<<FB, 0, 1<<FB, 5<<FB};
        push_tri(t);
        t.v = '{-(1<<FB), -(1<<FB), -(5<<FB), 3<<FB, -(1<<FB), -(5<<FB),
                -(1<<FB), 3<<FB, -(5<<FB)};
        push_tri(t);
        t.v = '{0, 0, 5<<FB, 1<<FB, 1<<FB, 5<<FB, 2<<FB, 2<<FB, 5<<FB};
        push_tri(t);
        t.v = '{-(1<<FB), 0, 0, 1<<FB, 0, 0, 0, 0, 1<<FB};
        push_tri(t);
        t.v = '{-(1<<FB), -(1<<FB), 1, 3<<FB, -(1<<FB), 1, -(1<<FB), 3<<FB, 1};
        push_tri(t);
        t.v = '{-(1<<FB), -(1<<FB), 32'sh7FFFFFFF, 3<<FB, -(1<<FB), 32'sh7FFFFFFF,
                -(1<<FB), 3<<FB, 32'sh7FFFFFFF};
        push_tri(t);
        for (int k = 0; k < 9; k++) t.v[k] = 32'sh80000000;
        push_tri(t);
        for (int k = 0; k < 9; k++) t.v[k] = (k % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
        push_tri(t);
        for (int k = 0; k < 9; k++) t.v[k] = 32'hFFFFFFFF;
        push_tri(t);
        drain();
        // pressure: long receiver hold while the sender keeps offering
        long_req = 1;
        for (int i = 0; i < 150; i++) push_tri(aimed_tri());
        wait (long_taken && long_left == 0);
        long_req = 0;
        // sender pause until all results are back
        hold_send = 1;
        wait (expected_outcomes.size() == 0);
        hold_send = 0;
      end
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        case ($urandom_range(0, 9))
          0: for (int k = 0; k < 9; k++) t.v[k] = rand_coord(0);
          1: for (int k = 0; k < 9; k++) t.v[k] = rand_coord($urandom_range(0, 2));
          2: for (int k = 0; k < 9; k++) t.v[k] = rand_coord(2);
          default: t = aimed_tri();
        endcase
        push_tri(t);
      end
      drain();
    end
    if (!failed && expected_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/rti_pkg.sv
rtl/rti_cross.sv
rtl/rti_dot.sv
rtl/rti_div.sv
rtl/ray_triangle_intersect_core.sv
rtl/rti_checker.sv
tb/tb_ray_triangle_intersect_core.sv
